// ----- hdl/tlpq_pkg.sv -----
// Package for the three-level priority queue.
// Holds sizing constants, command and status codes, and the pipeline meta type.
// No dependencies.
`default_nettype none

package tlpq_pkg;

    localparam int LEVEL_DEPTH = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

    localparam int IDX_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DATA_W = 8;
    localparam int LVL_W  = 2;
    localparam int ST_W   = 2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPRIO = 2'd3;

    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;

    typedef struct packed {
        logic              rd;
        logic [LVL_W-1:0]  level;
        logic [ST_W-1:0]   status;
    } tlpq_meta_t;

endpackage

`default_nettype wire

// ----- hdl/tlpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/three_level_priority_queue.sv -----
// Three-level priority queue of bytes, top level.
// Depends on tlpq_pkg and tlpq_ram.
`default_nettype none

// One word per cycle in unless stalled, one result word per input word out, in
// order. An input word is decided in the cycle it is accepted (priority encode
// over three level counts, one pointer update); the byte store is a RAM with
// registered read; a result passes the in-flight stage, then the output register.
// Sustained rate is one word per cycle while the output is not stalled; an output
// register plus one in-flight stage let one more word enter while a result waits.
// Each level holds LEVEL_DEPTH bytes; no clearing pass is needed after reset.
module three_level_priority_queue
    import tlpq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              command,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [1:0]        priority_req,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DATA_W-1:0] out_value,
    output logic      [LVL_W-1:0]  served_level,
    output logic      [ST_W-1:0]   status
);

    logic [IDX_W-1:0] head_reg  [NUM_LEVELS];
    logic [IDX_W-1:0] head_next [NUM_LEVELS];
    logic [IDX_W-1:0] tail_reg  [NUM_LEVELS];
    logic [IDX_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] count_next [NUM_LEVELS];

    logic              s1_valid_reg;
    logic              s1_valid_next;
    tlpq_meta_t        s1_meta_reg;
    tlpq_meta_t        meta_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [LVL_W-1:0]  served_level_reg;
    logic [ST_W-1:0]   status_reg;

    logic              accept;
    logic              s1_adv;
    logic              found;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if ({1'b0, p} == (IDX_W+1)'(LEVEL_DEPTH - 1))
            r = '0;
        else
            r = p + IDX_W'(1);
        return r;
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = '0;
        ram_raddr  = '0;
        found      = 1'b0;
        meta_next  = '{rd: 1'b0, level: LVL_NONE, status: ST_OK};
        if (accept)
        begin
            if (command == CMD_ENQ)
            begin
                if (priority_req == LVL_NONE)
                begin
                    meta_next.status = ST_BADPRIO;
                end
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    if (priority_req == LVL_W'(l + 1))
                    begin
                        meta_next.level = LVL_W'(l + 1);
                        if (count_reg[l] == CNT_W'(LEVEL_DEPTH))
                        begin
                            meta_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = ADDR_W'(l * LEVEL_DEPTH)
                                          + ADDR_W'(tail_reg[l]);
                            tail_next[l]  = next_slot(tail_reg[l]);
                            count_next[l] = count_reg[l] + CNT_W'(1);
                        end
                    end
                end
            end
            else
            begin
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    if (!found && count_reg[l] != '0)
                    begin
                        found         = 1'b1;
                        ram_re        = 1'b1;
                        ram_raddr     = ADDR_W'(l * LEVEL_DEPTH)
                                      + ADDR_W'(head_reg[l]);
                        head_next[l]  = next_slot(head_reg[l]);
                        count_next[l] = count_reg[l] - CNT_W'(1);
                        meta_next.rd    = 1'b1;
                        meta_next.level = LVL_W'(l + 1);
                    end
                end
                if (!found)
                begin
                    meta_next.status = ST_EMPTY;
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    tlpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
        end
        if (s1_adv)
        begin
            out_value_reg    <= s1_meta_reg.rd ? ram_rdata : '0;
            served_level_reg <= s1_meta_reg.level;
            status_reg       <= s1_meta_reg.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign served_level = served_level_reg;
    assign status       = status_reg;

    // level occupancy bounded by depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CNT_W'(LEVEL_DEPTH) && count_reg[1] <= CNT_W'(LEVEL_DEPTH)
        && count_reg[2] <= CNT_W'(LEVEL_DEPTH))
        else $error("level count above depth");

    // input only stalls when the in-flight stage is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with free pipeline");

    // rejected or empty results carry no byte
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_value == '0)
        else $error("nonzero byte on non-ok result");

    // empty result only when all levels were empty at decision time
    a_empty_real: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_DEQ && (count_reg[0] != '0 || count_reg[1] != '0
        || count_reg[2] != '0) |=> s1_meta_reg.status == ST_OK && s1_meta_reg.rd)
        else $error("dequeue missed a non-empty level");

    // bad priority leaves occupancy unchanged
    a_badprio_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_ENQ && priority_req == LVL_NONE
        |=> count_reg[0] == $past(count_reg[0]) && count_reg[1] == $past(count_reg[1])
        && count_reg[2] == $past(count_reg[2]))
        else $error("invalid priority changed a level");

endmodule

`default_nettype wire

// ----- tb/tlpq_result_checker.sv -----
// Result checker for the three-level priority queue testbench.
// Watches both word channels, predicts each result and compares it in order.
// Depends on tlpq_pkg.
`timescale 1ns / 1ps

module tlpq_result_checker
    import tlpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              command,
    input  logic [DATA_W-1:0] value,
    input  logic [1:0]        priority_req,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [DATA_W-1:0] out_value,
    input  logic [LVL_W-1:0]  served_level,
    input  logic [ST_W-1:0]   status,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [LVL_W-1:0]  level;
        logic [ST_W-1:0]   status;
    } access_result_t;

    logic [DATA_W-1:0] level_bytes [NUM_LEVELS][LEVEL_DEPTH];
    logic [IDX_W-1:0]  head_slot [NUM_LEVELS];
    logic [IDX_W-1:0]  tail_slot [NUM_LEVELS];
    logic [CNT_W-1:0]  fill [NUM_LEVELS];

    access_result_t due_results [$];
    access_result_t want;
    int             mismatches = 0;

    function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] p);
        return (p == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic access_result_t apply_word(logic cmd, logic [DATA_W-1:0] data,
                                                  logic [1:0] prio);
        access_result_t r;
        int             lv;
        logic           found;
        r.value  = '0;
        r.level  = LVL_NONE;
        r.status = ST_OK;
        found    = 1'b0;
        if (cmd == CMD_ENQ)
        begin
            if (prio == LVL_NONE)
                r.status = ST_BADPRIO;
            else
            begin
                lv      = int'(prio) - 1;
                r.level = prio;
                if (fill[lv] >= CNT_W'(LEVEL_DEPTH))
                    r.status = ST_FULL;
                else
                begin
                    level_bytes[lv][tail_slot[lv]] = data;
                    tail_slot[lv] = next_slot(tail_slot[lv]);
                    fill[lv]      = fill[lv] + 1'b1;
                end
            end
        end
        else
        begin
            r.status = ST_EMPTY;
            for (lv = 0; lv < NUM_LEVELS; lv++)
            begin
                if (!found && fill[lv] != 0)
                begin
                    found         = 1'b1;
                    r.value       = level_bytes[lv][head_slot[lv]];
                    r.level       = LVL_W'(lv + 1);
                    r.status      = ST_OK;
                    head_slot[lv] = next_slot(head_slot[lv]);
                    fill[lv]      = fill[lv] - 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_field(input string field, input int expected, input int actual);
        mismatches++;
        $error("%s: expected %0d, actual %0d", field, expected, actual);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_slot[i] = '0;
                tail_slot[i] = '0;
                fill[i]      = '0;
            end
            due_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $error("result word with nothing pending: value %0d level %0d status %0d",
                           out_value, served_level, status);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_value !== want.value)
                        report_field("out_value", want.value, out_value);
                    if (served_level !== want.level)
                        report_field("served_level", want.level, served_level);
                    if (status !== want.status)
                        report_field("status", want.status, status);
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(apply_word(command, value, priority_req));
            fail_count <= mismatches;
            pending    <= due_results.size();
        end
    end

endmodule

// ----- tb/three_level_priority_queue_test.sv -----
// Testbench top for the three-level priority queue.
// Drives directed and random enqueue/dequeue words with bursty input and random
// output stalls; depends on tlpq_pkg, three_level_priority_queue, tlpq_result_checker.
`timescale 1ns / 1ps

module three_level_priority_queue_test;
    import tlpq_pkg::*;

    localparam int RANDOM_WORDS = 1850;
    localparam int QUIET_LIMIT  = 2000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              command;
    logic [DATA_W-1:0] value;
    logic [1:0]        priority_req;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] out_value;
    logic [LVL_W-1:0]  served_level;
    logic [ST_W-1:0]   status;
    int                fail_count;
    int                pending;

    int burst_left = 0;
    int quiet_cycles = 0;
    int stall_pct;
    int sent;
    int k;
    int run_len;
    int deq_pct;
    int bad_pct;
    logic cmd_pick;

    three_level_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .value        (value),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_value    (out_value),
        .served_level (served_level),
        .status       (status)
    );

    tlpq_result_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .value        (value),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_value    (out_value),
        .served_level (served_level),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat ($urandom_range(20, 150))
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic cmd, input logic [DATA_W-1:0] data,
                             input logic [1:0] prio);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        value        <= data;
        priority_req <= prio;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    // hold input until every pending result word is out
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_ENQ;
        value        <= '0;
        priority_req <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_DEQ, 8'h00, 2'd0);
        send_word(CMD_ENQ, 8'hFF, 2'd0);
        for (k = 0; k < LEVEL_DEPTH; k++)
            send_word(CMD_ENQ, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : DATA_W'($urandom), 2'd3);
        send_word(CMD_ENQ, 8'h3C, 2'd3);
        send_word(CMD_ENQ, 8'hA5, 2'd1);
        send_word(CMD_ENQ, 8'h5A, 2'd2);
        send_word(CMD_DEQ, 8'hFF, 2'd3);
        send_word(CMD_DEQ, 8'h00, 2'd0);
        send_word(CMD_DEQ, 8'h81, 2'd1);
        drain_all();

        // runs biased toward filling, draining, mixing, or bad priorities
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            run_len = $urandom_range(10, 120);
            bad_pct = 4;
            case ($urandom_range(0, 3))
                0: deq_pct = 20;
                1: deq_pct = 80;
                2: deq_pct = 50;
                default:
                begin
                    deq_pct = 40;
                    bad_pct = 40;
                end
            endcase
            for (k = 0; k < run_len && sent < RANDOM_WORDS; k++)
            begin
                cmd_pick = ($urandom_range(0, 99) < deq_pct) ? CMD_DEQ : CMD_ENQ;
                if (cmd_pick == CMD_ENQ && $urandom_range(0, 99) >= bad_pct)
                    send_word(cmd_pick, DATA_W'($urandom), 2'($urandom_range(1, 3)));
                else if (cmd_pick == CMD_ENQ)
                    send_word(cmd_pick, DATA_W'($urandom), 2'd0);
                else
                    send_word(cmd_pick, DATA_W'($urandom), 2'($urandom));
                sent++;
                if (sent == RANDOM_WORDS / 2)
                    drain_all();
            end
        end

        drain_all();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tlpq_pkg.sv
hdl/tlpq_ram.sv
hdl/three_level_priority_queue.sv
tb/tlpq_result_checker.sv
tb/three_level_priority_queue_test.sv
